>>> sv/tsmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsmr_pkg
// Shared constants and types for the TCP SYN MSS rewriter.
// ----------------------------------------------------------------------------
package tsmr_pkg;

  // Byte offsets within the IPv6 packet (TCP header taken to start at 40)
  localparam logic [6:0] POS_NEXT_HDR = 7'd6;
  localparam logic [6:0] TCP_START    = 7'd40;
  localparam logic [6:0] POS_DOFF     = 7'd52;
  localparam logic [6:0] POS_FLAGS    = 7'd53;
  localparam logic [6:0] OPT_START    = 7'd60;
  localparam logic [6:0] POS_MAX      = 7'd127;

  // Header values and TCP option codes
  localparam logic [7:0] NEXT_HDR_TCP = 8'd6;
  localparam logic [7:0] KIND_END     = 8'd0;
  localparam logic [7:0] KIND_NOP     = 8'd1;
  localparam logic [7:0] KIND_MSS     = 8'd2;
  localparam logic [7:0] LEN_MSS      = 8'd4;
  localparam logic [7:0] LEN_MIN      = 8'd2;
  localparam int unsigned FLAG_SYN_BIT = 1;

  // Output queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // One output beat
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       changed;
  } beat_t;

  // Beats produced by one input byte
  typedef struct packed {
    logic [1:0] count;
    beat_t      first;
    beat_t      second;
  } result_t;

endpackage
`default_nettype wire

>>> sv/tsmr_parse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsmr_parse
// Per-byte header tracking, TCP option walk and MSS rewrite.
// ----------------------------------------------------------------------------
module tsmr_parse (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic             last_i,
  input  wire logic [15:0]      mss_decrease_i,
  output tsmr_pkg::result_t     result_o
);

  logic [6:0]  pos_q, pos_d;
  logic        is_tcp_q, is_tcp_d;
  logic        is_syn_q, is_syn_d;
  logic [6:0]  opt_end_q, opt_end_d;
  logic [6:0]  nos_q, nos_d;
  logic [7:0]  kind_q, kind_d;
  logic        is_mss_q, is_mss_d;
  logic        walk_done_q, walk_done_d;
  logic [7:0]  held_q, held_d;
  logic        holding_q, holding_d;

  logic [7:0]  pos_w;
  logic [7:0]  nos_w;
  logic [8:0]  ns_w;
  logic [15:0] mss_val;
  logic [15:0] mss_new;
  logic        mss_dec;
  logic        at_high;
  logic        at_low;

  assign pos_w   = {1'b0, pos_q};
  assign nos_w   = {1'b0, nos_q};
  assign ns_w    = {2'b00, nos_q} + {1'b0, byte_i};
  assign mss_val = {held_q, byte_i};
  assign mss_dec = mss_val > mss_decrease_i;
  assign mss_new = mss_dec ? (mss_val - mss_decrease_i) : mss_val;
  assign at_high = is_mss_q && !holding_q && (pos_w == nos_w + 8'd2);
  assign at_low  = is_mss_q && holding_q && (pos_w == nos_w + 8'd3);

  always_comb begin
    pos_d       = pos_q;
    is_tcp_d    = is_tcp_q;
    is_syn_d    = is_syn_q;
    opt_end_d   = opt_end_q;
    nos_d       = nos_q;
    kind_d      = kind_q;
    is_mss_d    = is_mss_q;
    walk_done_d = walk_done_q;
    held_d      = held_q;
    holding_d   = holding_q;

    result_o.count          = 2'd1;
    result_o.first.data     = byte_i;
    result_o.first.last     = last_i;
    result_o.first.changed  = 1'b0;
    result_o.second.data    = mss_new[7:0];
    result_o.second.last    = last_i;
    result_o.second.changed = mss_dec;

    if (at_high) begin
      if (last_i) begin
        is_mss_d = 1'b0;
      end else begin
        held_d         = byte_i;
        holding_d      = 1'b1;
        result_o.count = 2'd0;
      end
    end else if (at_low) begin
      result_o.first.data    = mss_new[15:8];
      result_o.first.last    = 1'b0;
      result_o.first.changed = mss_dec;
      result_o.count         = 2'd2;
      holding_d              = 1'b0;
      is_mss_d               = 1'b0;
    end else begin
      if (pos_q == tsmr_pkg::POS_NEXT_HDR) begin
        is_tcp_d = (byte_i == tsmr_pkg::NEXT_HDR_TCP);
      end else if (pos_q == tsmr_pkg::POS_DOFF) begin
        opt_end_d = tsmr_pkg::TCP_START + {1'b0, byte_i[7:4], 2'b00};
      end else if (pos_q == tsmr_pkg::POS_FLAGS) begin
        is_syn_d = byte_i[tsmr_pkg::FLAG_SYN_BIT];
      end

      // option walk, sees this byte's header updates
      if (is_tcp_d && is_syn_d && !walk_done_q) begin
        if (kind_q == tsmr_pkg::KIND_END && pos_q == nos_q) begin
          priority if (pos_q >= opt_end_d || byte_i == tsmr_pkg::KIND_END) begin
            walk_done_d = 1'b1;
          end else if (byte_i == tsmr_pkg::KIND_NOP) begin
            if (pos_w + 8'd1 >= {1'b0, opt_end_d}) begin
              walk_done_d = 1'b1;
            end else begin
              nos_d = pos_q + 7'd1;
            end
          end else begin
            kind_d = byte_i;
          end
        end else if (kind_q != tsmr_pkg::KIND_END && pos_w == nos_w + 8'd1) begin
          priority if (kind_q == tsmr_pkg::KIND_MSS && byte_i == tsmr_pkg::LEN_MSS) begin
            is_mss_d    = 1'b1;
            walk_done_d = 1'b1;
          end else if (byte_i < tsmr_pkg::LEN_MIN || ns_w >= {2'b00, opt_end_d}) begin
            walk_done_d = 1'b1;
          end else begin
            nos_d = ns_w[6:0];
          end
          kind_d = tsmr_pkg::KIND_END;
        end
      end
    end

    if (last_i) begin
      pos_d       = '0;
      is_tcp_d    = 1'b0;
      is_syn_d    = 1'b0;
      opt_end_d   = '0;
      nos_d       = tsmr_pkg::OPT_START;
      kind_d      = tsmr_pkg::KIND_END;
      is_mss_d    = 1'b0;
      walk_done_d = 1'b0;
      held_d      = '0;
      holding_d   = 1'b0;
    end else if (pos_q < tsmr_pkg::POS_MAX) begin
      pos_d = pos_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      is_tcp_q    <= 1'b0;
      is_syn_q    <= 1'b0;
      opt_end_q   <= '0;
      nos_q       <= tsmr_pkg::OPT_START;
      kind_q      <= tsmr_pkg::KIND_END;
      is_mss_q    <= 1'b0;
      walk_done_q <= 1'b0;
      held_q      <= '0;
      holding_q   <= 1'b0;
    end else if (fire_i) begin
      pos_q       <= pos_d;
      is_tcp_q    <= is_tcp_d;
      is_syn_q    <= is_syn_d;
      opt_end_q   <= opt_end_d;
      nos_q       <= nos_d;
      kind_q      <= kind_d;
      is_mss_q    <= is_mss_d;
      walk_done_q <= walk_done_d;
      held_q      <= held_d;
      holding_q   <= holding_d;
    end
  end

`ifndef SYNTHESIS
  // a held high byte only exists for a found MSS option
  a_hold_needs_mss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    holding_q |-> is_mss_q)
    else $error("tsmr_parse: holding without MSS option");

  // the walk never stops halfway through a kind/length pair
  a_done_no_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_done_q |-> (kind_q == tsmr_pkg::KIND_END))
    else $error("tsmr_parse: walk ended with a pending length byte");
`endif

endmodule
`default_nettype wire

>>> sv/tsmr_outq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsmr_outq
// Four-entry output queue, takes up to two beats per cycle, gives one while ready_i is high.
// ----------------------------------------------------------------------------
module tsmr_outq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  tsmr_pkg::result_t      result_i,
  output logic                   room_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output tsmr_pkg::beat_t        beat_o
);

  tsmr_pkg::beat_t                  mem_q [tsmr_pkg::QDEPTH];
  logic [tsmr_pkg::QPTR_W-1:0]      wr_q, wr_d;
  logic [tsmr_pkg::QPTR_W-1:0]      rd_q, rd_d;
  logic [tsmr_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic [tsmr_pkg::QCNT_W-1:0]      n_in;
  logic                             pop;

  assign n_in    = push_i ? {1'b0, result_i.count} : '0;
  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign beat_o  = mem_q[rd_q];
  // room for two beats keeps the worst case safe
  assign room_o  = (cnt_q <= tsmr_pkg::QCNT_W'(tsmr_pkg::QDEPTH - 2));

  assign wr_d  = wr_q + n_in[tsmr_pkg::QPTR_W-1:0];
  assign rd_d  = rd_q + tsmr_pkg::QPTR_W'(pop);
  assign cnt_d = cnt_q + n_in - tsmr_pkg::QCNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (n_in != '0) begin
      mem_q[wr_q] <= result_i.first;
    end
    if (n_in == tsmr_pkg::QCNT_W'(2)) begin
      mem_q[wr_q + tsmr_pkg::QPTR_W'(1)] <= result_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tsmr_pkg::QCNT_W'(tsmr_pkg::QDEPTH))
    else $error("tsmr_outq: queue overflow");
`endif

endmodule
`default_nettype wire

>>> sv/tcp_syn_mss_rewriter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_syn_mss_rewriter_top
// MSS clamping on an IPv6 byte stream: bytes pass through, the first MSS
// option of a TCP SYN is reduced by a configured amount.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata / data        | side bands
//  ----------+-----+---------------------+-------------------------------
//  s_axis    | in  | [7:0] in_byte       | tlast = in_last
//  m_axis    | out | [7:0] out_byte      | tlast = out_last, tuser = mss_changed
//  cfg       | in  | [15:0] mss_decrease | always ready
//
//  One byte a cycle sustained while the queue has room; each accepted byte is
//  parsed in the cycle of its transfer and queued in the four-entry m_axis queue.
//  The MSS high byte is held back and leaves together with the low byte: no
//  beat from the high byte's cycle, two from the low byte's; the queue absorbs it.
//  s_axis stalls only while the queue has fewer than two free entries.
//  Reset clears parser state, queue pointers and mss_decrease; no sweep needed.
// ----------------------------------------------------------------------------
module tcp_syn_mss_rewriter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,    // [7:0] in_byte
  input  wire logic        s_axis_tlast_i,
  // output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,    // [7:0] out_byte
  output logic             m_axis_tlast_o,
  output logic [0:0]       m_axis_tuser_o,    // [0] mss_changed
  // configuration write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i         // [15:0] mss_decrease
);

  logic                  s_fire;
  logic [15:0]           mss_decrease_q;
  tsmr_pkg::result_t     result;
  tsmr_pkg::beat_t       beat;

  assign s_fire      = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o = 1'b1;

  // clamp amount
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mss_decrease_q <= '0;
    end else if (cfg_valid_i) begin
      mss_decrease_q <= cfg_data_i;
    end
  end

  // header tracking and option walk
  tsmr_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (s_fire),
    .byte_i         (s_axis_tdata_i),
    .last_i         (s_axis_tlast_i),
    .mss_decrease_i (mss_decrease_q),
    .result_o       (result)
  );

  // result queue, decouples the two sides
  tsmr_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (s_fire),
    .result_i (result),
    .room_o   (s_axis_tready_o),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .beat_o   (beat)
  );

  assign m_axis_tdata_o = beat.data;
  assign m_axis_tlast_o = beat.last;
  assign m_axis_tuser_o = beat.changed;

`ifndef SYNTHESIS
  // input back-pressure only ever comes from a filled queue
  a_stall_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("tcp_syn_mss_rewriter_top: input stalled with empty queue");
`endif

endmodule
`default_nettype wire

>>> dv/tcp_syn_mss_rewriter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_syn_mss_rewriter_checker
// Watches the byte stream, the configuration write and the output stream of
// the MSS rewriter. Predicts every output beat from the accepted input bytes
// and compares each output transfer with the oldest predicted beat.
// ----------------------------------------------------------------------------
module tcp_syn_mss_rewriter_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,
  input  logic        m_tlast_i,
  input  logic [0:0]  m_tuser_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [15:0] mss_dec;

  // per-packet parser state
  logic [6:0]  byte_pos;
  logic        tcp_seen;
  logic        syn_seen;
  logic [6:0]  opt_end;
  logic [6:0]  next_opt;
  logic [7:0]  pend_kind;   // KIND_END: no length byte awaited
  logic        mss_armed;
  logic        walk_done;
  logic [7:0]  held_hi;
  logic        holding;

  tsmr_pkg::beat_t out_beats_q[$];
  int    mismatches = 0;

  function automatic void clear_packet();
    byte_pos  = '0;
    tcp_seen  = 1'b0;
    syn_seen  = 1'b0;
    opt_end   = '0;
    next_opt  = tsmr_pkg::OPT_START;
    pend_kind = tsmr_pkg::KIND_END;
    mss_armed = 1'b0;
    walk_done = 1'b0;
    held_hi   = '0;
    holding   = 1'b0;
  endfunction

  // Option walk, one byte at a time
  function automatic void walk_options(int unsigned p, logic [7:0] b);
    int unsigned nxt;
    int unsigned ns;
    nxt = next_opt;
    if (!tcp_seen || !syn_seen || walk_done) return;
    if (pend_kind == tsmr_pkg::KIND_END && p == nxt) begin
      if (p >= opt_end || b == tsmr_pkg::KIND_END) begin
        walk_done = 1'b1;
      end else if (b == tsmr_pkg::KIND_NOP) begin
        if (p + 1 >= opt_end) walk_done = 1'b1;
        else next_opt = 7'(p + 1);
      end else begin
        pend_kind = b;
      end
    end else if (pend_kind != tsmr_pkg::KIND_END && p == nxt + 1) begin
      ns = nxt + b;
      if (pend_kind == tsmr_pkg::KIND_MSS && b == tsmr_pkg::LEN_MSS) begin
        mss_armed = 1'b1;
        walk_done = 1'b1;
      end else if (b < tsmr_pkg::LEN_MIN || ns >= opt_end) begin
        walk_done = 1'b1;
      end else begin
        next_opt = 7'(ns);
      end
      pend_kind = tsmr_pkg::KIND_END;
    end
  endfunction

  // Beats caused by one accepted byte: none while the MSS high byte is held,
  // two when the low byte releases it, otherwise one.
  function automatic void clamp_byte(logic [7:0] b, logic l);
    int unsigned     p;
    int unsigned     nxt;
    logic [15:0]     mss;
    tsmr_pkg::beat_t bt;
    p  = byte_pos;
    nxt = next_opt;
    bt.data    = b;
    bt.last    = l;
    bt.changed = 1'b0;
    if (mss_armed && !holding && p == nxt + 2) begin
      if (l) begin
        mss_armed = 1'b0;
        out_beats_q.push_back(bt);
      end else begin
        held_hi = b;
        holding = 1'b1;
      end
    end else if (mss_armed && holding && p == nxt + 3) begin
      mss = {held_hi, b};
      if (mss > mss_dec) begin
        mss        = mss - mss_dec;
        bt.changed = 1'b1;
      end
      bt.data = mss[15:8];
      bt.last = 1'b0;
      out_beats_q.push_back(bt);
      bt.data = mss[7:0];
      bt.last = l;
      out_beats_q.push_back(bt);
      holding   = 1'b0;
      mss_armed = 1'b0;
    end else begin
      if (p == tsmr_pkg::POS_NEXT_HDR) tcp_seen = (b == tsmr_pkg::NEXT_HDR_TCP);
      else if (p == tsmr_pkg::POS_DOFF) opt_end = 7'(tsmr_pkg::TCP_START + b[7:4] * 4);
      else if (p == tsmr_pkg::POS_FLAGS) syn_seen = b[tsmr_pkg::FLAG_SYN_BIT];
      walk_options(p, b);
      out_beats_q.push_back(bt);
    end
    if (l) clear_packet();
    else if (byte_pos < tsmr_pkg::POS_MAX) byte_pos = byte_pos + 7'd1;
  endfunction

  always @(posedge clk_i) begin
    tsmr_pkg::beat_t want;
    if (!rst_ni) begin
      mss_dec = '0;
      clear_packet();
      out_beats_q.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) clamp_byte(s_tdata_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) begin
        if (out_beats_q.size() == 0) begin
          $error("unexpected output transfer: out_byte %0h", m_tdata_i);
          mismatches++;
        end else begin
          want = out_beats_q.pop_front();
          if (m_tdata_i !== want.data) begin
            $error("out_byte: expected %0h, got %0h", want.data, m_tdata_i);
            mismatches++;
          end
          if (m_tlast_i !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, m_tlast_i);
            mismatches++;
          end
          if (m_tuser_i[0] !== want.changed) begin
            $error("mss_changed: expected %0b, got %0b", want.changed, m_tuser_i[0]);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) mss_dec = cfg_data_i;
    end
    pending_o = out_beats_q.size();
  end

  assign fail_count_o = mismatches;

endmodule

>>> dv/tcp_syn_mss_rewriter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_syn_mss_rewriter_top_tb
// Feeds IPv6 packets byte by byte into the MSS rewriter: hand-built cases for
// the option walk, then random mostly-SYN packets with random option lists, noise
// and cut-short packets, under several decrease settings. A checker beside
// the block predicts and compares every output transfer.
// ----------------------------------------------------------------------------
module tcp_syn_mss_rewriter_top_tb;

  localparam int         CYCLE_LIMIT   = 500000;
  localparam int         RAND_BYTES    = 150;
  localparam int         SETTLE_CYCLES = 4;   // extra wait after the predicted beats have left
  localparam int         DRAIN_CYCLES  = 10;
  localparam int         CFG_EVERY     = 5;   // packets per decrease setting
  localparam logic [7:0] SYN_FLAG      = 8'(1 << tsmr_pkg::FLAG_SYN_BIT);
  localparam logic [7:0] NEXT_HDR_UDP  = 8'd17;
  localparam logic [7:0] KIND_WSCALE   = 8'd3;

  logic        clk_i;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic [0:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  int          fails;
  int          pending;
  int          cycle_cnt = 0;

  logic [7:0]  pkt_q[$];     // packet under construction
  logic [15:0] cur_dec = '0; // decrease currently programmed
  bit          calm = 1'b0;  // both sides run without gaps for this packet

  tcp_syn_mss_rewriter_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),    // [7:0] in_byte
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),    // [7:0] out_byte
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser),    // [0] mss_changed
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)    // [15:0] mss_decrease
  );

  tcp_syn_mss_rewriter_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .m_tuser_i    (m_tuser),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop should the block hang or lose a beat
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tcp_syn_mss_rewriter_top: mismatch");
      $finish;
    end
  end

  // Output side: before each transfer hold tready low for a random stall, unless
  // the current packet runs calm.
  initial begin
    int stall;
    m_tready <= 1'b0;
    wait (rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
    end
  end

  // ---- packet construction -------------------------------------------------

  // 60 random bytes with next header, data offset and flags set; options follow
  function automatic void syn_header(logic [7:0] nh, logic [3:0] doff, logic [7:0] flags);
    pkt_q.delete();
    repeat (tsmr_pkg::OPT_START) pkt_q.push_back(8'($urandom));
    pkt_q[tsmr_pkg::POS_NEXT_HDR] = nh;
    pkt_q[tsmr_pkg::POS_DOFF]     = {doff, 4'($urandom)};
    pkt_q[tsmr_pkg::POS_FLAGS]    = flags;
  endfunction

  function automatic void mss_opt(logic [15:0] val);
    pkt_q.push_back(tsmr_pkg::KIND_MSS);
    pkt_q.push_back(tsmr_pkg::LEN_MSS);
    pkt_q.push_back(val[15:8]);
    pkt_q.push_back(val[7:0]);
  endfunction

  function automatic void pad_to(int n);
    while (pkt_q.size() < n) pkt_q.push_back(8'($urandom));
  endfunction

  function automatic void cut_to(int n);
    while (pkt_q.size() > n) void'(pkt_q.pop_back());
  endfunction

  // MSS values aimed at the compare: extremes and both sides of the decrease
  function automatic logic [15:0] pick_mss();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return cur_dec;
      3:       return cur_dec + 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_decrease();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 2000));
      default: return 16'($urandom);
    endcase
  endfunction

  // TCP-like packet: a few leading options (some broken), usually an MSS,
  // padding to the options end, a short payload, now and then cut short.
  function automatic void option_packet(logic [7:0] nh, logic [7:0] flags);
    int         doff;
    int         mss_hi;
    logic [7:0] olen;
    doff   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 10);
    mss_hi = -1;
    syn_header(nh, 4'(doff), flags);
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 7))
        0, 1, 2: pkt_q.push_back(tsmr_pkg::KIND_NOP);
        3, 4: begin
          olen = 8'($urandom_range(2, 6));
          pkt_q.push_back(8'($urandom_range(3, 255)));
          pkt_q.push_back(olen);
          repeat (olen - 2) pkt_q.push_back(8'($urandom));
        end
        5: begin
          // MSS kind with a length other than four
          olen = 8'($urandom_range(0, 1) ? $urandom_range(2, 3) : $urandom_range(5, 6));
          pkt_q.push_back(tsmr_pkg::KIND_MSS);
          pkt_q.push_back(olen);
          repeat (olen - 2) pkt_q.push_back(8'($urandom));
        end
        6: pkt_q.push_back(tsmr_pkg::KIND_END);
        default: begin
          // length below two
          pkt_q.push_back(8'($urandom_range(2, 255)));
          pkt_q.push_back(8'($urandom_range(0, 1)));
        end
      endcase
    end
    if ($urandom_range(0, 7) != 0) begin
      mss_hi = pkt_q.size() + 2;
      mss_opt(pick_mss());
    end
    pad_to(tsmr_pkg::TCP_START + doff * 4);
    pad_to(pkt_q.size() + $urandom_range(0, 8));
    if ($urandom_range(0, 9) == 0) pad_to($urandom_range(100, 140));
    if ($urandom_range(0, 5) == 0) begin
      // end on the held high byte or the low byte, or anywhere past the header
      if (mss_hi >= 0 && $urandom_range(0, 1)) cut_to(mss_hi + 1 + $urandom_range(0, 1));
      else cut_to($urandom_range(tsmr_pkg::TCP_START + 1, pkt_q.size()));
    end
  endfunction

  function automatic void random_packet();
    logic [7:0] nh;
    case ($urandom_range(0, 9))
      0: begin
        pkt_q.delete();
        repeat ($urandom_range(1, 70)) pkt_q.push_back(8'($urandom));
      end
      1: begin
        nh = 8'($urandom);
        if (nh == tsmr_pkg::NEXT_HDR_TCP) nh = NEXT_HDR_UDP;
        option_packet(nh, 8'($urandom) | SYN_FLAG);
      end
      2:       option_packet(tsmr_pkg::NEXT_HDR_TCP, 8'($urandom) & ~SYN_FLAG);
      default: option_packet(tsmr_pkg::NEXT_HDR_TCP, 8'($urandom) | SYN_FLAG);
    endcase
  endfunction

  // ---- driving -------------------------------------------------------------

  // One byte transfer with a random gap ahead of it, unless the packet runs calm. tvalid stays
  // high across back-to-back transfers, so it is only lowered for a gap.
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  // Leaves tvalid high after the last transfer; the next send_byte or
  // write_cfg lowers or reuses it in the same step.
  task automatic send_packet();
    foreach (pkt_q[i]) send_byte(pkt_q[i], i == pkt_q.size() - 1);
  endtask

  // Register write only once every predicted beat has left the block
  task automatic write_cfg(input logic [15:0] val);
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    cur_dec = val;
  endtask

  task automatic directed_packets();
    write_cfg(16'h0000);
    // single-byte packets at both data extremes
    pkt_q = '{8'hFF};
    send_packet();
    pkt_q = '{8'h00};
    send_packet();
    // zero decrease: any nonzero MSS still counts as reduced, zero does not
    syn_header(tsmr_pkg::NEXT_HDR_TCP, 4'd6, SYN_FLAG);
    mss_opt(16'hFFFF);
    pad_to(64);
    send_packet();
    syn_header(tsmr_pkg::NEXT_HDR_TCP, 4'd6, SYN_FLAG);
    mss_opt(16'h0000);
    pad_to(66);
    send_packet();
    // largest decrease: equal value left alone
    write_cfg(16'hFFFF);
    syn_header(tsmr_pkg::NEXT_HDR_TCP, 4'd6, 8'hFF);
    mss_opt(16'hFFFF);
    pad_to(64);
    send_packet();
    write_cfg(16'd1000);
    // NOPs and another option ahead of the MSS
    syn_header(tsmr_pkg::NEXT_HDR_TCP, 4'd8, SYN_FLAG);
    pkt_q.push_back(tsmr_pkg::KIND_NOP);
    pkt_q.push_back(tsmr_pkg::KIND_NOP);
    pkt_q.push_back(KIND_WSCALE);
    pkt_q.push_back(8'd3);
    pkt_q.push_back(8'd7);
    mss_opt(16'd1460);
    pad_to(72);
    send_packet();
    // end-of-list stops the walk before the MSS
    syn_header(tsmr_pkg::NEXT_HDR_TCP, 4'd7, SYN_FLAG);
    pkt_q.push_back(tsmr_pkg::KIND_END);
    mss_opt(16'd1460);
    pad_to(68);
    send_packet();
    // length below two stops the walk
    syn_header(tsmr_pkg::NEXT_HDR_TCP, 4'd7, SYN_FLAG);
    pkt_q.push_back(KIND_WSCALE);
    pkt_q.push_back(8'd1);
    mss_opt(16'd1460);
    pad_to(68);
    send_packet();
    // MSS kind of the wrong length skipped, the following one taken
    syn_header(tsmr_pkg::NEXT_HDR_TCP, 4'd8, SYN_FLAG);
    pkt_q.push_back(tsmr_pkg::KIND_MSS);
    pkt_q.push_back(8'd5);
    pad_to(65);
    mss_opt(16'd1460);
    pad_to(72);
    send_packet();
    // short header: options never walked
    syn_header(tsmr_pkg::NEXT_HDR_TCP, 4'd4, SYN_FLAG);
    mss_opt(16'd1460);
    pad_to(64);
    send_packet();
    // MSS starting right at the options end
    syn_header(tsmr_pkg::NEXT_HDR_TCP, 4'd5, SYN_FLAG);
    mss_opt(16'd1460);
    pad_to(64);
    send_packet();
    // not TCP, then TCP without SYN
    syn_header(NEXT_HDR_UDP, 4'd6, SYN_FLAG);
    mss_opt(16'd1460);
    pad_to(64);
    send_packet();
    syn_header(tsmr_pkg::NEXT_HDR_TCP, 4'd6, ~SYN_FLAG);
    mss_opt(16'd1460);
    pad_to(64);
    send_packet();
    // kind on the last options byte: length and value lie past the end
    syn_header(tsmr_pkg::NEXT_HDR_TCP, 4'd6, SYN_FLAG);
    pkt_q.push_back(tsmr_pkg::KIND_NOP);
    pkt_q.push_back(tsmr_pkg::KIND_NOP);
    pkt_q.push_back(tsmr_pkg::KIND_NOP);
    mss_opt(16'd1460);
    pad_to(70);
    send_packet();
    // packet ends on the held high byte, then on the low byte
    syn_header(tsmr_pkg::NEXT_HDR_TCP, 4'd6, SYN_FLAG);
    mss_opt(16'd1460);
    cut_to(63);
    send_packet();
    syn_header(tsmr_pkg::NEXT_HDR_TCP, 4'd6, SYN_FLAG);
    mss_opt(16'd1460);
    send_packet();
    // long packet: byte position saturates
    syn_header(tsmr_pkg::NEXT_HDR_TCP, 4'd6, SYN_FLAG);
    mss_opt(16'd1460);
    pad_to(140);
    send_packet();
  endtask

  // ---- main sequence -------------------------------------------------------
  initial begin
    int rand_bytes;
    int pkt_cnt;
    rand_bytes = 0;
    pkt_cnt    = 0;
    rst_n     <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    directed_packets();

    // random packets, a fresh decrease every few packets
    while (rand_bytes < RAND_BYTES) begin
      if (pkt_cnt % CFG_EVERY == 0) write_cfg(pick_decrease());
      calm = ($urandom_range(0, 3) == 0);
      random_packet();
      rand_bytes += pkt_q.size();
      send_packet();
      pkt_cnt++;
    end

    // drain, then keep watching to catch any stray beat
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0)
      $display("tcp_syn_mss_rewriter_top: match");
    else
      $display("tcp_syn_mss_rewriter_top: mismatch");
    $finish;
  end

endmodule
